// ===== sv/gbhz_pkg.sv =====
// ----------------------------------------------------------------------------
// gbhz_pkg
// Shared types and constants for the GB18030 Hanzi counter.
// ----------------------------------------------------------------------------
package gbhz_pkg;

    localparam int unsigned COUNT_WIDTH_DEF = 32;
    localparam int unsigned OUT_WIDTH       = 32;
    localparam int unsigned BYTE_WIDTH      = 8;

    typedef enum logic [1:0] {
        PH_LEAD   = 2'd0,
        PH_SECOND = 2'd1,
        PH_SKIP2  = 2'd2,
        PH_SKIP1  = 2'd3
    } t_phase;

    // decoder -> counter, one per accepted word
    typedef struct packed {
        logic hit;   // completed pair is a Hanzi
        logic last;  // word closes the string
        logic cut;   // string ends inside a multibyte sequence
    } t_step;

endpackage

// ===== sv/gbhz_decode.sv =====
// ----------------------------------------------------------------------------
// gbhz_decode
// Byte phase tracker: holds the open lead byte and classifies each pair.
// ----------------------------------------------------------------------------
module gbhz_decode
    import gbhz_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic [BYTE_WIDTH-1:0] i_byte,
    input  logic                  i_last,
    output t_step                 o_step
);

    t_phase                r_phase;
    t_phase                n_phase;
    logic [BYTE_WIDTH-1:0] r_lead;
    logic [BYTE_WIDTH-1:0] n_lead;
    logic                  hit;

    function automatic logic is_hanzi(input logic [7:0] lead, input logic [7:0] trail);
        logic res;
        begin
            res = 1'b0;
            if (lead inside {[8'hB0:8'hF7]}) begin
                res = trail inside {[8'hA1:8'hFE]};
            end else if (lead inside {[8'h81:8'hA0]}) begin
                res = trail inside {[8'h40:8'h7E], [8'h80:8'hFE]};
            end else if (lead inside {[8'hAA:8'hFE]}) begin
                res = trail inside {[8'h40:8'h7E], [8'h80:8'hA0]};
            end
            return res;
        end
    endfunction

    // next phase
    always_comb begin
        n_phase = PH_LEAD;
        n_lead  = r_lead;
        hit     = 1'b0;
        case (r_phase)
            PH_LEAD: begin
                // 0x80 and 0xFF fall through as single bytes
                if (i_byte inside {[8'h81:8'hFE]}) begin
                    n_phase = PH_SECOND;
                    n_lead  = i_byte;
                end
            end
            PH_SECOND: begin
                if (i_byte inside {[8'h30:8'h39]}) begin
                    n_phase = PH_SKIP2;
                end else begin
                    hit = is_hanzi(r_lead, i_byte);
                end
            end
            PH_SKIP2: begin
                n_phase = PH_SKIP1;
            end
            PH_SKIP1: begin
                n_phase = PH_LEAD;
            end
            default: begin
                n_phase = PH_LEAD;
            end
        endcase
    end

    // outputs
    always_comb begin
        o_step.hit  = hit;
        o_step.last = i_last;
        o_step.cut  = (n_phase != PH_LEAD);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_LEAD;
            r_lead  <= '0;
        end else if (i_en) begin
            if (i_last) begin
                r_phase <= PH_LEAD;
                r_lead  <= '0;
            end else begin
                r_phase <= n_phase;
                r_lead  <= n_lead;
            end
        end
    end

endmodule

// ===== sv/gbhz_count.sv =====
// ----------------------------------------------------------------------------
// gbhz_count
// Saturating Hanzi counter and result register.
// ----------------------------------------------------------------------------
module gbhz_count
    import gbhz_pkg::*;
#(
    parameter int unsigned COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  t_step                i_step,
    input  logic                 i_take,
    output logic                 o_valid,
    output logic [OUT_WIDTH-1:0] o_count,
    output logic                 o_cut
);

    // count saturates at the smaller of the parameter width and the port
    localparam int unsigned CntW = (COUNT_WIDTH > OUT_WIDTH) ? OUT_WIDTH : COUNT_WIDTH;

    logic [CntW-1:0] r_total;
    logic [CntW-1:0] n_total;
    logic            r_valid;
    logic [CntW-1:0] r_count;
    logic            r_cut;

    assign n_total = (i_step.hit && (r_total != {CntW{1'b1}})) ? r_total + 1'b1 : r_total;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total <= '0;
            r_valid <= 1'b0;
        end else begin
            if (i_en) begin
                r_total <= i_step.last ? '0 : n_total;
            end
            if (i_en && i_step.last) begin
                r_valid <= 1'b1;
            end else if (i_take) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en && i_step.last) begin
            r_count <= n_total;
            r_cut   <= i_step.cut;
        end
    end

    assign o_valid = r_valid;
    assign o_count = OUT_WIDTH'(r_count);
    assign o_cut   = r_cut;

endmodule

// ===== sv/gb18030_hanzi_counter.sv =====
// ----------------------------------------------------------------------------
// gb18030_hanzi_counter
// Counts two-byte GB18030 Hanzi in a byte stream, one result per string.
// ----------------------------------------------------------------------------
//  channel | dir | tdata                 | tlast       | tuser
//  s       | in  | [7:0] byte_value      | last        | -
//  m       | out | [31:0] hanzi_count    | -           | [0] cut_short
//
//  One byte word is taken per cycle while s_tready is high; the phase update
//  sits between the phase register and the result register.
//  The result appears in the cycle after the word marked tlast is taken.
//  Reset (synchronous, active low) clears phase, count and the result valid.
//  s_tready is low only while a result is held and m_tready is low.
// ----------------------------------------------------------------------------
module gb18030_hanzi_counter
    import gbhz_pkg::*;
#(
    parameter int unsigned COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  logic [BYTE_WIDTH-1:0] i_s_tdata,  // [7:0] byte_value
    input  logic                  i_s_tlast,
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    output logic [OUT_WIDTH-1:0]  o_m_tdata,  // [31:0] hanzi_count
    output logic [0:0]            o_m_tuser   // [0] cut_short
);

    logic  accept;
    t_step step;
    logic  cut;

    assign o_s_tready = !o_m_tvalid || i_m_tready;
    assign accept     = i_s_tvalid && o_s_tready;

    gbhz_decode u_decode (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (accept),
        .i_byte  (i_s_tdata),
        .i_last  (i_s_tlast),
        .o_step  (step)
    );

    gbhz_count #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_count (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (accept),
        .i_step  (step),
        .i_take  (i_m_tready),
        .o_valid (o_m_tvalid),
        .o_count (o_m_tdata),
        .o_cut   (cut)
    );

    assign o_m_tuser = cut;

endmodule

// ===== sv/gbhz_checker.sv =====
// ----------------------------------------------------------------------------
// gbhz_checker
// Port-level checks for the Hanzi counter, bound to the top level.
// ----------------------------------------------------------------------------
module gbhz_checker
    import gbhz_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_s_tvalid,
    input logic                  o_s_tready,
    input logic                  i_s_tlast,
    input logic                  o_m_tvalid,
    input logic                  i_m_tready,
    input logic [OUT_WIDTH-1:0]  o_m_tdata
);

    // a word closing a string always yields a result next cycle
    a_last_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready && i_s_tlast) |=> o_m_tvalid)
        else $error("no result after last word");

    // a new result only follows a word marked last
    a_result_needs_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_tvalid) |-> $past(i_s_tvalid && o_s_tready && i_s_tlast))
        else $error("result without last word");

    // input side never stalls while the result register is empty
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_tvalid |-> o_s_tready)
        else $error("input stalled with empty result register");

    // stalled result holds
    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> (o_m_tvalid && $stable(o_m_tdata)))
        else $error("stalled result changed");

endmodule

bind gb18030_hanzi_counter gbhz_checker u_gbhz_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .i_s_tlast  (i_s_tlast),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);
